>>> src/lkts_pkg.sv
package lkts_pkg;

	localparam int SLOTS     = 1024;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int HASH_W    = 64;
	localparam int STAGE_W   = 3;
	localparam int STAMP_W   = 64;
	localparam int OUT_IDX_W = 10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [HASH_W-1:0]  hash;
		logic [STAGE_W-1:0] stage;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// sequencer to compare unit
	typedef struct packed {
		logic             start;
		logic             eval;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

	// compare unit outcome
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] chosen;
	} scan_res_t;

endpackage

>>> src/lkts_ram.sv
module lkts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/lkts_scan.sv
module lkts_scan
	import lkts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctl_t          ctl,
	input  entry_t             entry,
	input  logic [HASH_W-1:0]  key_q,
	input  logic [STAGE_W-1:0] stage_q,
	input  logic [CNT_W-1:0]   fill_cnt,
	output logic               match,
	output scan_res_t          res
);

	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   victim_q;
	logic [STAMP_W-1:0] victim_stamp_q;
	logic               slot_valid;
	logic [STAMP_W-1:0] stamp_eff;
	logic               take;

	// slots fill from the top down, so the valid ones are the highest fill_cnt
	assign slot_valid = CNT_W'(ctl.idx) >= (CNT_W'(SLOTS) - fill_cnt);
	assign stamp_eff  = slot_valid ? entry.stamp : '0;
	assign match      = ctl.eval && slot_valid && (entry.hash == key_q)
		&& (entry.stage == stage_q);
	assign take       = (ctl.idx == '0) || !slot_valid || (stamp_eff < victim_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.start) begin
			hit_q <= 1'b0;
		end else if (match) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			hit_idx_q <= ctl.idx;
		end else if (ctl.eval && take) begin
			victim_q       <= ctl.idx;
			victim_stamp_q <= stamp_eff;
		end
	end

	assign res.hit    = hit_q;
	assign res.chosen = hit_q ? hit_idx_q : victim_q;

endmodule

>>> src/lkts_ctrl.sv
module lkts_ctrl
	import lkts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_free,
	input  logic             match,
	output logic             in_ready,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	output logic             fire,
	output scan_ctl_t        scan_ctl
);

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] rd_addr_q;
	logic             last_issued_q;
	logic             eval_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             scan_stop;
	logic             accept;

	assign scan_stop = (state_q == ST_SCAN) && eval_s1
		&& (match || (idx_s1 == IDX_W'(SLOTS - 1)));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_stop) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		fire     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN: begin
				rd_en = !last_issued_q;
			end
			ST_DONE: begin
				fire = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept         = in_valid && in_ready;
	assign rd_addr        = rd_addr_q;
	assign scan_ctl.start = accept;
	assign scan_ctl.eval  = eval_s1 && (state_q == ST_SCAN);
	assign scan_ctl.idx   = idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_addr_q     <= '0;
			last_issued_q <= 1'b0;
			eval_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			// read data of the slot issued this cycle is compared next cycle
			eval_s1 <= rd_en && !scan_stop;
			if (accept) begin
				rd_addr_q     <= '0;
				last_issued_q <= 1'b0;
			end else if (rd_en) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_addr_q == IDX_W'(SLOTS - 1)) begin
					last_issued_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_addr_q;
		end
	end

endmodule

>>> src/lru_keyed_tag_store.sv
// fully associative tag store with timestamp lru replacement
// input channel (in_valid/in_ready) carries key_hash, shader_stage and fill_ok;
// output channel (out_valid/out_ready) returns hit, slot_index and success.
// each item scans the slot store in index order through one ram read port,
// one slot a cycle, with a single shared compare unit checking the key and
// the use stamp against the running victim
// a hit ends the scan at the matching slot and a miss scans every slot; one
// item is in work at a time, so a new item is not taken until the scan over
// the ram port and the update of the last one are through
// in_ready is high only while the block is idle; the result sits in an output
// register, and the next item can be taken while it waits
// a stalled receiver holds the finished item in the update step, so no slot
// is written until the output register is free
// reset empties the store at once: a fill count marks which slots are valid,
// so there is no clearing pass, and the use counter returns to zero
module lru_keyed_tag_store
	import lkts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [HASH_W-1:0]    key_hash,
	input  logic [STAGE_W-1:0]   shader_stage,
	input  logic                 fill_ok,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [OUT_IDX_W-1:0] slot_index,
	output logic                 success
);

	logic [HASH_W-1:0]            key_q;
	logic [STAGE_W-1:0]           stage_q;
	logic                         fill_q;
	logic [CNT_W-1:0]             fill_cnt_q;
	logic [STAMP_W-1:0]           use_cnt_q;
	logic                         out_valid_q;
	logic                         hit_q;
	logic [OUT_IDX_W-1:0]         slot_index_q;
	logic                         success_q;
	logic                         out_free;
	logic                         match;
	logic                         rd_en;
	logic [IDX_W-1:0]             rd_addr;
	logic                         fire;
	scan_ctl_t                    scan_ctl;
	scan_res_t                    res;
	entry_t                       rd_entry;
	entry_t                       wr_entry;
	logic                         success_d;
	logic                         wr_en;
	logic [STAMP_W-1:0]           use_next;
	logic [IDX_W+OUT_IDX_W-1:0]   idx_ext;

	assign out_free = !out_valid_q || out_ready;

	lkts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.match    (match),
		.in_ready (in_ready),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.fire     (fire),
		.scan_ctl (scan_ctl)
	);

	lkts_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (res.chosen),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	lkts_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.entry    (rd_entry),
		.key_q    (key_q),
		.stage_q  (stage_q),
		.fill_cnt (fill_cnt_q),
		.match    (match),
		.res      (res)
	);

	assign success_d      = res.hit || fill_q;
	assign wr_en          = fire && success_d;
	assign use_next       = use_cnt_q + 1'b1;
	assign wr_entry.hash  = key_q;
	assign wr_entry.stage = stage_q;
	assign wr_entry.stamp = use_next;
	assign idx_ext        = {{OUT_IDX_W{1'b0}}, res.chosen};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q   <= key_hash;
			stage_q <= shader_stage;
			fill_q  <= fill_ok;
		end
		if (fire) begin
			hit_q        <= res.hit;
			slot_index_q <= idx_ext[OUT_IDX_W-1:0];
			success_q    <= success_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q  <= '0;
			use_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				use_cnt_q <= use_next;
				// a miss lands on an empty slot while any remain
				if (!res.hit && (fill_cnt_q != CNT_W'(SLOTS))) begin
					fill_cnt_q <= fill_cnt_q + 1'b1;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign slot_index = slot_index_q;
	assign success    = success_q;

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_cnt_q <= CNT_W'(SLOTS))
		else $error("fill count beyond slot count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !res.hit && fill_q && (fill_cnt_q != CNT_W'(SLOTS)))
		|-> (CNT_W'(res.chosen) == (CNT_W'(SLOTS) - fill_cnt_q - 1'b1)))
		else $error("fill did not pick the highest empty slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && hit_q) |-> success_q)
		else $error("hit reported without success");

	assert property (@(posedge clk) disable iff (!arst_n)
		(use_cnt_q != $past(use_cnt_q)) |-> $past(wr_en))
		else $error("use counter moved without a slot update");

	assert property (@(posedge clk) disable iff (!arst_n)
		match |-> !res.hit)
		else $error("second match within one scan");
`endif

endmodule

>>> tb/sv/lkts_lookup_check.sv
`timescale 1ns / 1ps

module lkts_lookup_check
	import lkts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [HASH_W-1:0]    key_hash,
	input  logic [STAGE_W-1:0]   shader_stage,
	input  logic                 fill_ok,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 hit,
	input  logic [OUT_IDX_W-1:0] slot_index,
	input  logic                 success,
	output int unsigned          fail_count,
	output int unsigned          pending,
	output int unsigned          hits_seen,
	output int unsigned          fills_seen,
	output int unsigned          refusals_seen
);

	typedef struct packed {
		logic                 hit;
		logic [OUT_IDX_W-1:0] slot;
		logic                 success;
	} lookup_res_t;

	// shadow copy of the tag store
	logic               line_valid [SLOTS];
	logic [HASH_W-1:0]  line_hash  [SLOTS];
	logic [STAGE_W-1:0] line_stage [SLOTS];
	logic [STAMP_W-1:0] line_stamp [SLOTS];
	logic [STAMP_W-1:0] use_clock;

	lookup_res_t awaited_results [$];

	// scan in slot order, stop on the first live match, otherwise keep the
	// last empty slot or the oldest stamp as the replacement candidate
	function automatic lookup_res_t lookup_and_touch(input logic [HASH_W-1:0] h,
			input logic [STAGE_W-1:0] s, input logic f);
		int          victim;
		int          chosen;
		logic        found;
		lookup_res_t r;
		victim = 0;
		chosen = 0;
		found  = 1'b0;
		for (int i = 0; i < SLOTS && !found; i++) begin
			if (line_valid[i] && line_hash[i] == h && line_stage[i] == s) begin
				found  = 1'b1;
				chosen = i;
			end else if (!line_valid[i] || line_stamp[i] < line_stamp[victim]) begin
				victim = i;
			end
		end
		if (!found) begin
			chosen = victim;
			if (!f) begin
				// refused fill leaves everything alone, counter included
				r.hit     = 1'b0;
				r.slot    = chosen[OUT_IDX_W-1:0];
				r.success = 1'b0;
				refusals_seen++;
				return r;
			end
			line_valid[chosen] = 1'b1;
			line_hash[chosen]  = h;
			line_stage[chosen] = s;
			fills_seen++;
		end else begin
			hits_seen++;
		end
		use_clock          = use_clock + 1'b1;
		line_stamp[chosen] = use_clock;
		r.hit     = found;
		r.slot    = chosen[OUT_IDX_W-1:0];
		r.success = 1'b1;
		return r;
	endfunction

	function automatic void note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_res_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				line_valid[i] = 1'b0;
				line_hash[i]  = '0;
				line_stage[i] = '0;
				line_stamp[i] = '0;
			end
			use_clock = '0;
			awaited_results.delete();
			fail_count    = 0;
			pending       = 0;
			hits_seen     = 0;
			fills_seen    = 0;
			refusals_seen = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(lookup_and_touch(key_hash, shader_stage, fill_ok));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					note_failure($sformatf("result with nothing outstanding: hit=%0b slot=%0d success=%0b",
						hit, slot_index, success));
				end else begin
					want = awaited_results.pop_front();
					if (want.hit !== hit || want.slot !== slot_index || want.success !== success)
						note_failure($sformatf(
							"lookup mismatch: expected hit=%0b slot=%0d success=%0b, got hit=%0b slot=%0d success=%0b",
							want.hit, want.slot, want.success, hit, slot_index, success));
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import lkts_pkg::*;

	localparam int IDLE_PCT       = 12;
	localparam int RANDOM_ITEMS   = 500;
	localparam int RX_HOLD_CYCLES = 4000;
	localparam int STALL_LIMIT    = 20000;
	localparam int TAIL_CYCLES    = SLOTS + 16;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [HASH_W-1:0]    key_hash;
	logic [STAGE_W-1:0]   shader_stage;
	logic                 fill_ok;
	logic                 out_valid;
	logic                 out_ready;
	logic                 hit;
	logic [OUT_IDX_W-1:0] slot_index;
	logic                 success;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned hits_seen;
	int unsigned fills_seen;
	int unsigned refusals_seen;
	int unsigned quiet_cycles;
	int unsigned lookups_sent;

	logic calm;
	logic rx_hold_req;

	logic [HASH_W-1:0]  pool_hash  [$];
	logic [STAGE_W-1:0] pool_stage [$];

	lru_keyed_tag_store dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_hash     (key_hash),
		.shader_stage (shader_stage),
		.fill_ok      (fill_ok),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.slot_index   (slot_index),
		.success      (success)
	);

	lkts_lookup_check u_lookup_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.key_hash      (key_hash),
		.shader_stage  (shader_stage),
		.fill_ok       (fill_ok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.slot_index    (slot_index),
		.success       (success),
		.fail_count    (fail_count),
		.pending       (pending),
		.hits_seen     (hits_seen),
		.fills_seen    (fills_seen),
		.refusals_seen (refusals_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles where neither channel moves an item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic push_lookup(input logic [HASH_W-1:0] h, input logic [STAGE_W-1:0] s,
			input logic f);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		key_hash     <= h;
		shader_stage <= s;
		fill_ok      <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		lookups_sent++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	initial begin
		logic [HASH_W-1:0]  h;
		logic [STAGE_W-1:0] s;
		logic [STAGE_W-1:0] bump;
		logic               f;
		int                 pick;
		int                 k;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		key_hash     = '0;
		shader_stage = '0;
		fill_ok      = 1'b0;
		calm         = 1'b0;
		rx_hold_req  = 1'b0;
		lookups_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, refused fill, hit with fill clear, stage-only difference
		push_lookup('0, 3'd0, 1'b0);
		push_lookup('0, 3'd0, 1'b1);
		push_lookup('0, 3'd0, 1'b0);
		push_lookup('0, 3'd7, 1'b1);
		push_lookup('1, 3'd7, 1'b1);
		push_lookup('1, 3'd7, 1'b0);
		// refused fill must not move the victim
		push_lookup('1, 3'd0, 1'b0);
		push_lookup('1, 3'd0, 1'b1);
		push_lookup('0, 3'd7, 1'b0);
		push_lookup(64'hAAAA_AAAA_AAAA_AAAA, 3'd5, 1'b1);
		push_lookup(64'h5555_5555_5555_5555, 3'd2, 1'b1);
		push_lookup(64'h7FFF_FFFF_FFFF_FFFF, 3'd7, 1'b1);
		push_lookup(64'hFFFF_FFFF_FFFF_FFFE, 3'd7, 1'b0);
		push_lookup(64'h8000_0000_0000_0000, 3'd3, 1'b1);
		push_lookup(64'h0000_0000_0000_0001, 3'd4, 1'b1);
		push_lookup(64'hAAAA_AAAA_AAAA_AAAA, 3'd5, 1'b1);
		push_lookup(64'h5555_5555_5555_5555, 3'd2, 1'b0);
		push_lookup('0, 3'd0, 1'b1);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 120 && n < 126) || (n >= 200 && n < 280);
			if (n == 120)
				rx_hold_req = 1'b1;
			if (n == 330)
				drain_results();
			pick = $urandom_range(99);
			h    = {$urandom, $urandom};
			s    = STAGE_W'($urandom_range(7));
			f    = ($urandom_range(99) < 80);
			if (pool_hash.size() > 0 && pick < 60) begin
				// mostly revisit known keys so hits and refreshes dominate
				k = $urandom_range(pool_hash.size() - 1);
				h = pool_hash[k];
				s = pool_stage[k];
				if (pick >= 45 && pick < 53) begin
					bump = STAGE_W'($urandom_range(1, 7));
					s    = s ^ bump;
				end else if (pick >= 53) begin
					h[$urandom_range(HASH_W - 1)] ^= 1'b1;
				end
			end else begin
				pool_hash.push_back(h);
				pool_stage.push_back(s);
				if (pool_hash.size() > 48) begin
					void'(pool_hash.pop_front());
					void'(pool_stage.pop_front());
				end
			end
			push_lookup(h, s, f);
		end
		calm = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d lookups: %0d hits, %0d fills, %0d refused fills",
			lookups_sent, hits_seen, fills_seen, refusals_seen);
		$display("included a long receiver hold-off with input stall and a full drain pause");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
